// File: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared definitions for the circular deque
// Sizes, command and status codes, and the control/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DEPTH       = 16;
	localparam int WORD_BITS   = 32;
	localparam int SLOT_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_BITS  = $clog2(DEPTH + 1);
	localparam int CAP_BITS    = 5;
	localparam int CMP_BITS    = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
	localparam int CMD_BITS    = 3;
	localparam int STATUS_BITS = 2;

	localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

	typedef logic [CMD_BITS-1:0] cmd_t;

	localparam cmd_t CMD_PUSH_FRONT = 3'd0;
	localparam cmd_t CMD_PUSH_BACK  = 3'd1;
	localparam cmd_t CMD_POP_FRONT  = 3'd2;
	localparam cmd_t CMD_POP_BACK   = 3'd3;
	localparam cmd_t CMD_LIST       = 3'd4;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK,
		ST_OVERFLOW,
		ST_UNDERFLOW,
		ST_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		DP_NONE,
		DP_PUSH_FRONT,
		DP_PUSH_BACK,
		DP_POP_FRONT,
		DP_POP_BACK,
		DP_LIST_START,
		DP_LIST_READ,
		DP_LIST_NEXT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		logic    out_load;
		status_t out_status;
		logic    out_from_mem;
		logic    out_last;
	} dp_cmd_t;

	typedef struct packed {
		logic                  empty;
		logic                  full;
		logic                  list_last;
		logic [COUNT_BITS-1:0] count;
	} dp_stat_t;

endpackage

// File: rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath: ring store, end pointers and result register
// Holds the capacity register, the front/back/scan pointers, the item count
// and the word memory, and loads the result register on command.
// ----------------------------------------------------------------------------
module cdq_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cdq_pkg::CAP_BITS-1:0]         cfg_data,
	input  logic [cdq_pkg::WORD_BITS-1:0]        push_word,
	input  cdq_pkg::dp_cmd_t                     cmd,
	output cdq_pkg::dp_stat_t                    stat,
	output cdq_pkg::status_t                     status,
	output logic [cdq_pkg::WORD_BITS-1:0]        out_word,
	output logic                                 last_flag
);

	localparam int SB = cdq_pkg::SLOT_BITS;
	localparam int CB = cdq_pkg::COUNT_BITS;
	localparam int WB = cdq_pkg::WORD_BITS;

	logic [cdq_pkg::CAP_BITS-1:0] capacity_q;
	logic [SB-1:0]                front_q, back_q, scan_q;
	logic [CB-1:0]                count_q, left_q;
	logic [WB-1:0]                mem_q [cdq_pkg::DEPTH];
	logic [WB-1:0]                rd_data_q;
	cdq_pkg::status_t             status_q;
	logic [WB-1:0]                word_q;
	logic                         last_q;

	logic [CB-1:0] cap_active, modulus;
	logic [SB-1:0] front_next, front_prev, back_next, back_prev, scan_next;
	logic          wr_en, rd_en;
	logic [SB-1:0] wr_addr, rd_addr;

	// Step one slot forward within the active ring
	function automatic logic [SB-1:0] slot_next(input logic [SB-1:0] s,
			input logic [CB-1:0] m);
		logic [CB-1:0] s1;
		s1 = CB'(s) + CB'(1);
		return (s1 >= m) ? SB'(0) : s1[SB-1:0];
	endfunction

	// Step one slot back within the active ring
	function automatic logic [SB-1:0] slot_prev(input logic [SB-1:0] s,
			input logic [CB-1:0] m);
		logic [CB-1:0] m1;
		m1 = m - CB'(1);
		return (s == SB'(0) || CB'(s) > m) ? m1[SB-1:0] : s - SB'(1);
	endfunction

	// Clamp capacity to the store depth; wrap modulus is never below one
	always_comb begin
		if (cdq_pkg::CMP_BITS'(capacity_q) > cdq_pkg::CMP_BITS'(cdq_pkg::DEPTH))
			cap_active = CB'(cdq_pkg::DEPTH);
		else
			cap_active = CB'(capacity_q);
		modulus = (cap_active == CB'(0)) ? CB'(1) : cap_active;
	end

	assign front_next = slot_next(front_q, modulus);
	assign front_prev = slot_prev(front_q, modulus);
	assign back_next  = slot_next(back_q, modulus);
	assign back_prev  = slot_prev(back_q, modulus);
	assign scan_next  = slot_next(scan_q, modulus);

	assign stat.empty     = (count_q == CB'(0));
	assign stat.full      = (count_q >= cap_active);
	assign stat.list_last = (left_q == CB'(1));
	assign stat.count     = count_q;

	// Select memory addresses for the current command
	always_comb begin
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		wr_addr = front_prev;
		rd_addr = front_q;
		case (cmd.op)
			cdq_pkg::DP_PUSH_FRONT: begin
				wr_en   = 1'b1;
				wr_addr = stat.empty ? SB'(0) : front_prev;
			end
			cdq_pkg::DP_PUSH_BACK: begin
				wr_en   = 1'b1;
				wr_addr = stat.empty ? SB'(0) : back_next;
			end
			cdq_pkg::DP_POP_FRONT: begin
				rd_en   = 1'b1;
				rd_addr = front_q;
			end
			cdq_pkg::DP_POP_BACK: begin
				rd_en   = 1'b1;
				rd_addr = back_q;
			end
			cdq_pkg::DP_LIST_READ: begin
				rd_en   = 1'b1;
				rd_addr = scan_q;
			end
			default: begin
				wr_en = 1'b0;
				rd_en = 1'b0;
			end
		endcase
	end

	// Word memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= push_word;
		if (rd_en)
			rd_data_q <= mem_q[rd_addr];
	end

	// Capacity, pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= cdq_pkg::CAP_RESET;
			front_q    <= '0;
			back_q     <= '0;
			count_q    <= '0;
			scan_q     <= '0;
			left_q     <= '0;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
			front_q    <= '0;
			back_q     <= '0;
			count_q    <= '0;
		end else begin
			case (cmd.op)
				cdq_pkg::DP_PUSH_FRONT: begin
					if (stat.empty) begin
						front_q <= '0;
						back_q  <= '0;
					end else begin
						front_q <= front_prev;
					end
					count_q <= count_q + CB'(1);
				end
				cdq_pkg::DP_PUSH_BACK: begin
					if (stat.empty) begin
						front_q <= '0;
						back_q  <= '0;
					end else begin
						back_q <= back_next;
					end
					count_q <= count_q + CB'(1);
				end
				cdq_pkg::DP_POP_FRONT: begin
					front_q <= front_next;
					count_q <= count_q - CB'(1);
				end
				cdq_pkg::DP_POP_BACK: begin
					back_q  <= back_prev;
					count_q <= count_q - CB'(1);
				end
				cdq_pkg::DP_LIST_START: begin
					scan_q <= front_q;
					left_q <= count_q;
				end
				cdq_pkg::DP_LIST_NEXT: begin
					scan_q <= scan_next;
					left_q <= left_q - CB'(1);
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			word_q   <= cmd.out_from_mem ? rd_data_q : '0;
			last_q   <= cmd.out_last;
		end
	end

	assign status    = status_q;
	assign out_word  = word_q;
	assign last_flag = last_q;

endmodule

// File: rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: command sequencer for the circular deque
// Decodes each accepted item, steps pops and lists through the memory read,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module cdq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  cdq_pkg::cmd_t         command,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  cdq_pkg::dp_stat_t     stat,
	output cdq_pkg::dp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_WAIT,
		S_LIST_RD,
		S_LIST_WR
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !(state_q == S_IDLE && out_free);
	assign accept   = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// Decode commands and sequence memory reads
	always_comb begin
		cmd.op           = cdq_pkg::DP_NONE;
		cmd.out_load     = 1'b0;
		cmd.out_status   = cdq_pkg::ST_OK;
		cmd.out_from_mem = 1'b0;
		cmd.out_last     = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
							cmd.out_load = 1'b1;
							if (stat.full)
								cmd.out_status = cdq_pkg::ST_OVERFLOW;
							else if (command == cdq_pkg::CMD_PUSH_FRONT)
								cmd.op = cdq_pkg::DP_PUSH_FRONT;
							else
								cmd.op = cdq_pkg::DP_PUSH_BACK;
						end
						cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
							if (stat.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = cdq_pkg::ST_UNDERFLOW;
							end else if (command == cdq_pkg::CMD_POP_FRONT) begin
								cmd.op = cdq_pkg::DP_POP_FRONT;
							end else begin
								cmd.op = cdq_pkg::DP_POP_BACK;
							end
						end
						cdq_pkg::CMD_LIST: begin
							if (stat.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = cdq_pkg::ST_EMPTY;
							end else begin
								cmd.op = cdq_pkg::DP_LIST_START;
							end
						end
						default: begin
							cmd.op = cdq_pkg::DP_NONE;
						end
					endcase
				end
			end
			S_POP_WAIT: begin
				cmd.out_load     = 1'b1;
				cmd.out_from_mem = 1'b1;
			end
			S_LIST_RD: begin
				cmd.op = cdq_pkg::DP_LIST_READ;
			end
			S_LIST_WR: begin
				if (out_free) begin
					cmd.op           = cdq_pkg::DP_LIST_NEXT;
					cmd.out_load     = 1'b1;
					cmd.out_from_mem = 1'b1;
					cmd.out_last     = stat.list_last;
				end
			end
			default: begin
				cmd.op = cdq_pkg::DP_NONE;
			end
		endcase
	end

	// Hold state and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.op inside {cdq_pkg::DP_POP_FRONT, cdq_pkg::DP_POP_BACK})
						state_q <= S_POP_WAIT;
					else if (cmd.op == cdq_pkg::DP_LIST_START)
						state_q <= S_LIST_RD;
				end
				S_POP_WAIT: begin
					state_q <= S_IDLE;
				end
				S_LIST_RD: begin
					state_q <= S_LIST_WR;
				end
				S_LIST_WR: begin
					if (out_free)
						state_q <= stat.list_last ? S_IDLE : S_LIST_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a ring of words
// Top level: joins the command sequencer to the ring datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one command per item: push
//   front, push back, pop front, pop back or list. Output channel
//   (out_valid/out_stall) returns results with status, out_word and
//   last_flag; last_flag marks the final result of each item.
//   Results: a push, or a pop or list meeting an empty deque, shows its
//   result in the cycle after acceptance. A pop reads the word memory into
//   a read register, then loads the result register; a list does so for
//   each word, front to back. Throughput: one push per cycle unless the
//   receiver stalls; a pop or list takes no new item until its last result
//   is loaded, set by the registered read port of the memory.
//   A new item is taken only when the sequencer is idle and the result
//   register is empty or being taken.
//   Reset empties the deque and sets capacity to 16. A capacity write also
//   empties it. While the receiver stalls, the result is held and the
//   block stops taking items.
// ----------------------------------------------------------------------------
module circular_deque (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cdq_pkg::CAP_BITS-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [cdq_pkg::CMD_BITS-1:0]          command,
	input  logic [cdq_pkg::WORD_BITS-1:0]         push_word,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cdq_pkg::STATUS_BITS-1:0]       status,
	output logic [cdq_pkg::WORD_BITS-1:0]         out_word,
	output logic                                  last_flag
);

	cdq_pkg::dp_cmd_t  dp_cmd;
	cdq_pkg::dp_stat_t dp_stat;
	cdq_pkg::status_t  dp_status;

	cdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.command   (command),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	cdq_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.push_word (push_word),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.status    (dp_status),
		.out_word  (out_word),
		.last_flag (last_flag)
	);

	assign status = dp_status;

	// Item count never exceeds the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.count <= cdq_pkg::COUNT_BITS'(cdq_pkg::DEPTH))
		else $error("item count above depth");

	// Pop of an empty deque answers with underflow next cycle
	a_pop_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !cfg_we && dp_stat.empty &&
		 (command == cdq_pkg::CMD_POP_FRONT || command == cdq_pkg::CMD_POP_BACK))
		|=> (out_valid && status == cdq_pkg::ST_UNDERFLOW))
		else $error("pop of empty deque gave no underflow");

	// Successful push leaves the deque non-empty
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !cfg_we && !dp_stat.full &&
		 (command == cdq_pkg::CMD_PUSH_FRONT || command == cdq_pkg::CMD_PUSH_BACK))
		|=> !dp_stat.empty)
		else $error("push left deque empty");

endmodule

// File: sim/deque_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_checker: result predictor and comparator for the circular deque
// Watches the capacity port and both item channels, keeps its own copy of
// the ring, the two ends and the fill level, and compares every result
// taken from the block, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module deque_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cdq_pkg::CAP_BITS-1:0]    cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [cdq_pkg::CMD_BITS-1:0]    command,
	input  logic [cdq_pkg::WORD_BITS-1:0]   push_word,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [cdq_pkg::STATUS_BITS-1:0] status,
	input  logic [cdq_pkg::WORD_BITS-1:0]   out_word,
	input  logic                            last_flag,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		cdq_pkg::status_t              st;
		logic [cdq_pkg::WORD_BITS-1:0] word;
		logic                          last;
	} deque_result_t;

	// results predicted but not yet seen, oldest first
	deque_result_t replies_due[$];

	// shadow copy of the deque
	logic [cdq_pkg::WORD_BITS-1:0] ring [cdq_pkg::DEPTH];
	int head_slot = 0;
	int tail_slot = 0;
	int fill = 0;
	int cap_reg = cdq_pkg::CAP_RESET;
	int err_count = 0;

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// slots in use: the register clamped to the ring size
	function automatic int used_slots();
		return (cap_reg > cdq_pkg::DEPTH) ? cdq_pkg::DEPTH : cap_reg;
	endfunction

	// slots the ends wrap within, never below one
	function automatic int ring_span();
		return (used_slots() == 0) ? 1 : used_slots();
	endfunction

	function automatic int slot_after(input int s);
		return (s + 1 >= ring_span()) ? 0 : s + 1;
	endfunction

	function automatic int slot_before(input int s);
		return (s == 0 || s > ring_span()) ? ring_span() - 1 : s - 1;
	endfunction

	task automatic add_reply(input cdq_pkg::status_t s,
			input logic [cdq_pkg::WORD_BITS-1:0] w, input logic l);
		replies_due.push_back('{st: s, word: w, last: l});
	endtask

	// apply one command to the shadow deque and queue the results it gives
	task automatic run_deque_command(input cdq_pkg::cmd_t c,
			input logic [cdq_pkg::WORD_BITS-1:0] w);
		int s;
		case (c)
			cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
				if (fill >= used_slots()) begin
					add_reply(cdq_pkg::ST_OVERFLOW, '0, 1'b1);
				end else begin
					// a push into an empty deque restarts both ends at slot 0
					if (fill == 0) begin
						head_slot = 0;
						tail_slot = 0;
						ring[0] = w;
					end else if (c == cdq_pkg::CMD_PUSH_FRONT) begin
						head_slot = slot_before(head_slot);
						ring[head_slot] = w;
					end else begin
						tail_slot = slot_after(tail_slot);
						ring[tail_slot] = w;
					end
					fill++;
					add_reply(cdq_pkg::ST_OK, '0, 1'b1);
				end
			end
			cdq_pkg::CMD_POP_FRONT: begin
				if (fill == 0) begin
					add_reply(cdq_pkg::ST_UNDERFLOW, '0, 1'b1);
				end else begin
					add_reply(cdq_pkg::ST_OK, ring[head_slot], 1'b1);
					head_slot = slot_after(head_slot);
					fill--;
				end
			end
			cdq_pkg::CMD_POP_BACK: begin
				if (fill == 0) begin
					add_reply(cdq_pkg::ST_UNDERFLOW, '0, 1'b1);
				end else begin
					add_reply(cdq_pkg::ST_OK, ring[tail_slot], 1'b1);
					tail_slot = slot_before(tail_slot);
					fill--;
				end
			end
			cdq_pkg::CMD_LIST: begin
				if (fill == 0) begin
					add_reply(cdq_pkg::ST_EMPTY, '0, 1'b1);
				end else begin
					// walk front to back, mark the back word as last
					s = head_slot;
					for (int k = 0; k < fill; k++) begin
						add_reply(cdq_pkg::ST_OK, ring[s], k == fill - 1);
						s = slot_after(s);
					end
				end
			end
			default: begin
				// spare codes: no result, no change
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		deque_result_t want;
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			fill = 0;
			cap_reg = cdq_pkg::CAP_RESET;
			replies_due.delete();
			outstanding <= 0;
		end else begin
			// compare the result taken at this edge before adding new predictions
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					if (err_count < REPORT_LIMIT)
						$display("[%0t] unexpected result: status %0d word %h last %b",
							$time, status, out_word, last_flag);
					err_count++;
				end else begin
					want = replies_due.pop_front();
					if (status != want.st || out_word != want.word ||
							last_flag != want.last) begin
						if (err_count < REPORT_LIMIT)
							$display({"[%0t] result mismatch: expected status %s word %h ",
								"last %b, got status %0d word %h last %b"}, $time,
								want.st.name(), want.word, want.last,
								status, out_word, last_flag);
						err_count++;
					end
				end
			end
			// a capacity write empties the deque
			if (cfg_we) begin
				cap_reg = cfg_data;
				fill = 0;
				head_slot = 0;
				tail_slot = 0;
			end
			if (in_valid && !in_stall)
				run_deque_command(command, push_word);
			mismatches <= err_count;
			outstanding <= replies_due.size();
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the circular deque
// Runs a directed pass over empty, full, wrap and spare-code cases at small
// capacities, then random phases over several capacities, each phase first
// filling and then draining the deque, with random gaps and stalls on both
// channels outside phase 0. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

	localparam int            PHASES        = 8;
	localparam int            PHASE_ITEMS   = 48;
	localparam int            IDLE_PERCENT  = 21;
	localparam int            SETTLE_CYCLES = 16;
	localparam int            WATCHDOG_MAX  = 4000;
	localparam cdq_pkg::cmd_t CMD_SPARE_A   = cdq_pkg::CMD_LIST + 3'd1;
	localparam cdq_pkg::cmd_t CMD_SPARE_B   = cdq_pkg::CMD_LIST + 3'd2;
	localparam cdq_pkg::cmd_t CMD_SPARE_C   = cdq_pkg::CMD_LIST + 3'd3;

	logic                            clk;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [cdq_pkg::CAP_BITS-1:0]    cfg_data  = '0;
	logic                            in_valid  = 1'b0;
	logic                            in_stall;
	cdq_pkg::cmd_t                   command   = cdq_pkg::CMD_PUSH_FRONT;
	logic [cdq_pkg::WORD_BITS-1:0]   push_word = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [cdq_pkg::STATUS_BITS-1:0] status;
	logic [cdq_pkg::WORD_BITS-1:0]   out_word;
	logic                            last_flag;

	logic steady = 1'b0;
	int   mismatches;
	int   outstanding;
	int   quiet_cycles = 0;

	circular_deque dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.push_word (push_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.out_word  (out_word),
		.last_flag (last_flag)
	);

	deque_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.push_word   (push_word),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.out_word    (out_word),
		.last_flag   (last_flag),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// stall the result channel at random, except in the steady phase
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one item, with a random gap first, and hold it until taken
	task automatic send_cmd(input cdq_pkg::cmd_t c,
			input logic [cdq_pkg::WORD_BITS-1:0] w);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= c;
		push_word <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// hold the sender until every predicted result has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// write capacity only once the block is idle
	task automatic write_capacity(input logic [cdq_pkg::CAP_BITS-1:0] v);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_data <= v;
		cfg_we   <= 1'b1;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	function automatic logic [cdq_pkg::WORD_BITS-1:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	// lean toward pushes while filling, toward pops while draining
	function automatic cdq_pkg::cmd_t pick_command(input bit filling);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return cdq_pkg::cmd_t'($urandom_range(CMD_SPARE_C, CMD_SPARE_A));
		if (r < 15)
			return cdq_pkg::CMD_LIST;
		if (r < (filling ? 50 : 35))
			return cdq_pkg::CMD_PUSH_FRONT;
		if (r < (filling ? 75 : 50))
			return cdq_pkg::CMD_PUSH_BACK;
		if (r < (filling ? 88 : 75))
			return cdq_pkg::CMD_POP_FRONT;
		return cdq_pkg::CMD_POP_BACK;
	endfunction

	initial begin
		cdq_pkg::cmd_t                c;
		int                           sent;
		logic [cdq_pkg::CAP_BITS-1:0] cap;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty, full, overflow, wrap, spare codes at capacity 3
		write_capacity(5'd3);
		send_cmd(cdq_pkg::CMD_POP_FRONT, '1);
		send_cmd(cdq_pkg::CMD_POP_BACK, '1);
		send_cmd(cdq_pkg::CMD_LIST, '1);
		send_cmd(cdq_pkg::CMD_PUSH_FRONT, '0);
		send_cmd(cdq_pkg::CMD_PUSH_BACK, '1);
		send_cmd(cdq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
		send_cmd(cdq_pkg::CMD_PUSH_BACK, 32'hDEAD_BEEF);
		send_cmd(cdq_pkg::CMD_PUSH_FRONT, 32'hCAFE_F00D);
		send_cmd(cdq_pkg::CMD_LIST, '0);
		send_cmd(cdq_pkg::CMD_POP_FRONT, '0);
		send_cmd(cdq_pkg::CMD_POP_BACK, '0);
		send_cmd(cdq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
		send_cmd(cdq_pkg::CMD_LIST, '0);
		send_cmd(cdq_pkg::CMD_POP_FRONT, '0);
		send_cmd(cdq_pkg::CMD_POP_FRONT, '0);
		send_cmd(cdq_pkg::CMD_POP_BACK, '0);
		send_cmd(CMD_SPARE_A, 32'hAAAA_AAAA);
		send_cmd(CMD_SPARE_B, '1);
		send_cmd(CMD_SPARE_C, '0);
		send_cmd(cdq_pkg::CMD_LIST, '0);

		// directed: zero capacity refuses every push
		write_capacity(5'd0);
		send_cmd(cdq_pkg::CMD_PUSH_FRONT, 32'h0F0F_0F0F);
		send_cmd(cdq_pkg::CMD_PUSH_BACK, 32'hF0F0_F0F0);
		send_cmd(cdq_pkg::CMD_POP_FRONT, '0);
		send_cmd(cdq_pkg::CMD_LIST, '0);

		// random phases, capacity extremes and clamped values among them
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cap = cdq_pkg::CAP_RESET;
				1: cap = 5'd1;
				2: cap = 5'd31;
				3: cap = 5'd5;
				4: cap = 5'd17;
				5: cap = 5'd2;
				default: cap = cdq_pkg::CAP_BITS'($urandom_range(31));
			endcase
			write_capacity(cap);
			steady <= (p == 0);
			for (int half = 0; half < 2; half++) begin
				sent = 0;
				while (sent < PHASE_ITEMS / 2) begin
					c = pick_command(half == 0);
					send_cmd(c, pick_word());
					if (c <= cdq_pkg::CMD_LIST)
						sent++;
				end
				if (half == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
rtl/cdq_pkg.sv
rtl/cdq_datapath.sv
rtl/cdq_ctrl.sv
rtl/circular_deque.sv
sim/deque_checker.sv
sim/testbench.sv
